>>> hdl/keyword_token_scanner_defines.svh
// Assertion macros shared by the keyword token scanner modules
`ifndef KEYWORD_TOKEN_SCANNER_DEFINES_SVH
`define KEYWORD_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, reset masked
`define KTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define KTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/kts_pkg.sv
// Shared types and constants for the keyword token scanner
package kts_pkg;

  typedef enum logic [3:0] {
    TK_EOF       = 4'd0,
    TK_MISSION   = 4'd1,
    TK_OBJECTIVE = 4'd2,
    TK_XP        = 4'd3,
    TK_WORD      = 4'd4,
    TK_NUMBER    = 4'd5,
    TK_LBRACE    = 4'd6,
    TK_RBRACE    = 4'd7,
    TK_SEMICOLON = 4'd8,
    TK_ERROR     = 4'd9
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNEXPECTED   = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } error_kind_t;

  localparam int OUT_W = 16;

  typedef struct packed {
    token_kind_t       token_kind;
    error_kind_t       error_kind;
    logic [7:0]        bad_character;
    logic [OUT_W-1:0]  start_line;
    logic [OUT_W-1:0]  start_column;
    logic [OUT_W-1:0]  token_length;
    logic              last_of_run;
  } token_t;

  // results of one transfer, up to two
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam int MISSION_LEN   = 7;
  localparam int OBJECTIVE_LEN = 9;
  localparam int XP_LEN        = 2;

  localparam logic [7:0] KW_MISSION [MISSION_LEN] =
    '{"M", "I", "S", "S", "I", "O", "N"};
  localparam logic [7:0] KW_OBJECTIVE [OBJECTIVE_LEN] =
    '{"O", "B", "J", "E", "C", "T", "I", "V", "E"};
  localparam logic [7:0] KW_XP [XP_LEN] = '{"X", "P"};

endpackage

>>> hdl/kts_channels.sv
// Handshake channels: source bytes in, tokens out
interface kts_byte_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink (input valid, kind, byte_value, output ready);
endinterface

interface kts_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [1:0]  error_kind;
  logic [7:0]  bad_character;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, token_kind, error_kind, bad_character, start_line,
                  start_column, token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, bad_character, start_line,
                start_column, token_length, last_of_run, output ready);
endinterface

>>> hdl/kts_lexer.sv
// Lexer state and per-byte token decision
`include "keyword_token_scanner_defines.svh"

module kts_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  kts_byte_if.sink        source_bytes,
  input  logic            room,
  output kts_pkg::push_t  push
);
  import kts_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int EW = (PB > OUT_W) ? PB : OUT_W;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  mode_t          mode, mode_next;
  logic [PB-1:0]  line, line_next;
  logic [PB-1:0]  col, col_next;
  logic [PB-1:0]  tline, tline_next;
  logic [PB-1:0]  tcol, tcol_next;
  logic [PB-1:0]  cnt, cnt_next;
  logic [2:0]     kwm, kwm_next;

  logic           fire;
  logic [7:0]     b;
  logic           is_alpha, is_digit, is_blank;
  logic [2:0]     kw_hit, kw_first;
  logic [PB-1:0]  cons_line, cons_col, cnt_inc;
  token_kind_t    word_kind;
  logic           pend_v, dir_v;
  token_t         pend, dir;

  function automatic logic [PB-1:0] sat_inc(logic [PB-1:0] v);
    sat_inc = (&v) ? v : v + PB'(1);
  endfunction

  function automatic logic [OUT_W-1:0] clamp(logic [PB-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    clamp = (e > EW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
  endfunction

  function automatic token_t make_token(token_kind_t tk, error_kind_t ek,
                                        logic [7:0] bad, logic [PB-1:0] ln,
                                        logic [PB-1:0] cl, logic [PB-1:0] len);
    token_t t;
    t.token_kind    = tk;
    t.error_kind    = ek;
    t.bad_character = bad;
    t.start_line    = clamp(ln);
    t.start_column  = clamp(cl);
    t.token_length  = clamp(len);
    t.last_of_run   = 1'b0;
    make_token = t;
  endfunction

  assign fire = source_bytes.valid && source_bytes.ready;
  assign source_bytes.ready = room;
  assign b = source_bytes.byte_value;

  assign is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  assign is_digit = (b >= "0" && b <= "9");
  assign is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);

  assign kw_hit[0] = (cnt < PB'(MISSION_LEN)) && (KW_MISSION[cnt[2:0]] == b);
  assign kw_hit[1] = (cnt < PB'(OBJECTIVE_LEN)) && (KW_OBJECTIVE[cnt[3:0]] == b);
  assign kw_hit[2] = (cnt < PB'(XP_LEN)) && (KW_XP[cnt[0]] == b);
  assign kw_first  = {b == KW_XP[0], b == KW_OBJECTIVE[0], b == KW_MISSION[0]};

  assign cons_line = (b == CH_LF) ? sat_inc(line) : line;
  assign cons_col  = (b == CH_LF) ? PB'(1) : sat_inc(col);
  assign cnt_inc   = sat_inc(cnt);

  always_comb begin
    if (kwm[0] && cnt == PB'(MISSION_LEN)) begin
      word_kind = TK_MISSION;
    end else if (kwm[1] && cnt == PB'(OBJECTIVE_LEN)) begin
      word_kind = TK_OBJECTIVE;
    end else if (kwm[2] && cnt == PB'(XP_LEN)) begin
      word_kind = TK_XP;
    end else begin
      word_kind = TK_WORD;
    end
  end

  always_comb begin
    mode_next  = mode;
    line_next  = line;
    col_next   = col;
    tline_next = tline;
    tcol_next  = tcol;
    cnt_next   = cnt;
    kwm_next   = kwm;
    pend_v     = 1'b0;
    dir_v      = 1'b0;
    pend       = '0;
    dir        = '0;
    if (fire) begin
      // a word or number still open is closed first
      case (mode)
        MODE_IDENT: begin
          pend = make_token(word_kind, ERR_NONE, 8'd0, tline, tcol, cnt);
        end
        MODE_NUMBER: begin
          pend = make_token(TK_NUMBER, ERR_NONE, 8'd0, tline, tcol, cnt);
        end
        MODE_STRING: begin
          pend = make_token(TK_ERROR, ERR_UNTERMINATED, 8'd0, tline, tcol, cnt);
        end
        default: begin
          pend = '0;
        end
      endcase
      if (source_bytes.kind) begin
        pend_v     = (mode != MODE_IDLE);
        dir_v      = 1'b1;
        dir        = make_token(TK_EOF, ERR_NONE, 8'd0, line, col, PB'(0));
        mode_next  = MODE_IDLE;
        line_next  = PB'(1);
        col_next   = PB'(1);
        tline_next = PB'(1);
        tcol_next  = PB'(1);
        cnt_next   = PB'(0);
        kwm_next   = 3'b111;
      end else begin
        line_next = cons_line;
        col_next  = cons_col;
        if (mode == MODE_STRING) begin
          if (b == CH_QUOTE) begin
            dir_v     = 1'b1;
            dir       = make_token(TK_WORD, ERR_NONE, 8'd0, tline, tcol, cnt);
            mode_next = MODE_IDLE;
          end else begin
            cnt_next = cnt_inc;
          end
        end else if (mode == MODE_IDENT && (is_alpha || is_digit)) begin
          kwm_next = kwm & kw_hit;
          cnt_next = cnt_inc;
        end else if (mode == MODE_NUMBER && is_digit) begin
          cnt_next = cnt_inc;
        end else begin
          pend_v     = (mode != MODE_IDLE);
          mode_next  = MODE_IDLE;
          tline_next = line;
          tcol_next  = col;
          if (is_blank) begin
            dir_v = 1'b0;
          end else if (is_alpha) begin
            mode_next = MODE_IDENT;
            kwm_next  = kw_first;
            cnt_next  = PB'(1);
          end else if (is_digit) begin
            mode_next = MODE_NUMBER;
            cnt_next  = PB'(1);
          end else if (b == CH_QUOTE) begin
            mode_next = MODE_STRING;
            cnt_next  = PB'(0);
          end else if (b == CH_LBRACE) begin
            dir_v = 1'b1;
            dir   = make_token(TK_LBRACE, ERR_NONE, 8'd0, line, col, PB'(1));
          end else if (b == CH_RBRACE) begin
            dir_v = 1'b1;
            dir   = make_token(TK_RBRACE, ERR_NONE, 8'd0, line, col, PB'(1));
          end else if (b == CH_SEMI) begin
            dir_v = 1'b1;
            dir   = make_token(TK_SEMICOLON, ERR_NONE, 8'd0, line, col, PB'(1));
          end else begin
            dir_v = 1'b1;
            dir   = make_token(TK_ERROR, ERR_UNEXPECTED, b, line, col, PB'(1));
          end
        end
      end
    end
  end

  // pack results in order, mark the last one
  always_comb begin
    push.count = {1'b0, pend_v} + {1'b0, dir_v};
    if (pend_v) begin
      push.first  = pend;
      push.second = dir;
    end else begin
      push.first  = dir;
      push.second = '0;
    end
    if (push.count == 2'd2) begin
      push.second.last_of_run = 1'b1;
    end else if (push.count == 2'd1) begin
      push.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      line  <= PB'(1);
      col   <= PB'(1);
      tline <= PB'(1);
      tcol  <= PB'(1);
      cnt   <= PB'(0);
      kwm   <= 3'b111;
    end else begin
      mode  <= mode_next;
      line  <= line_next;
      col   <= col_next;
      tline <= tline_next;
      tcol  <= tcol_next;
      cnt   <= cnt_next;
      kwm   <= kwm_next;
    end
  end

  `KTS_ASSERT_NOW(a_no_push_idle, clk, rst, !fire, push.count == 2'd0, "results without transfer")
  `KTS_ASSERT_NOW(a_last_marks, clk, rst, push.count == 2'd2, !push.first.last_of_run && push.second.last_of_run, "last_of_run misplaced")
  `KTS_ASSERT_NEXT(a_end_resets, clk, rst, fire && source_bytes.kind, mode == MODE_IDLE && line == PB'(1) && col == PB'(1), "end marker did not reset")

endmodule

>>> hdl/kts_result_fifo.sv
// Small result queue between the lexer and the token channel
`include "keyword_token_scanner_defines.svh"

module kts_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  kts_pkg::push_t  push,
  output logic            room,
  kts_token_if.source     tokens
);
  import kts_pkg::*;

  localparam int CNT_W = PTR_W + 1;

  token_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]    wp, rp;
  logic [CNT_W-1:0]    count, count_next;
  logic                pop;
  token_t              head;

  assign room = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign pop  = tokens.valid && tokens.ready;
  assign head = mem[rp];

  assign tokens.valid         = (count != '0);
  assign tokens.token_kind    = head.token_kind;
  assign tokens.error_kind    = head.error_kind;
  assign tokens.bad_character = head.bad_character;
  assign tokens.start_line    = head.start_line;
  assign tokens.start_column  = head.start_column;
  assign tokens.token_length  = head.token_length;
  assign tokens.last_of_run   = head.last_of_run;

  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wp + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PTR_W'(push.count);
      rp    <= rp + PTR_W'(pop);
      count <= count_next;
    end
  end

  `KTS_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, count <= CNT_W'(FIFO_DEPTH), "queue overfilled")
  `KTS_ASSERT_NEXT(a_drain_step, clk, rst, pop && push.count == 2'd0, count == $past(count) - CNT_W'(1), "pop did not drain")
  `KTS_ASSERT_NOW(a_push_room, clk, rst, push.count != 2'd0, room, "push without room")

endmodule

>>> hdl/keyword_token_scanner.sv
// Keyword token scanner top level
//
//  channel        dir  payload
//  source_bytes   in   kind, byte_value
//  tokens         out  token_kind, error_kind, bad_character, start_line,
//                      start_column, token_length, last_of_run
//
// One byte transfer per cycle while source_bytes.ready is high; its results
// reach the token queue next cycle. Up to two tokens per byte; the four-entry
// queue drains one token per cycle while tokens.ready is high.
// source_bytes.ready drops while fewer than two queue slots are free.
// Synchronous reset returns position to line 1, column 1 and empties the queue.
module keyword_token_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  kts_byte_if.sink     source_bytes,
  kts_token_if.source  tokens
);
  import kts_pkg::*;

  push_t push;
  logic  room;

  kts_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .source_bytes (source_bytes),
    .room         (room),
    .push         (push)
  );

  kts_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

>>> tb/tb_keyword_token_scanner.sv
// Self-checking testbench for the keyword token scanner: streamed bytes against a token predictor
`timescale 1ns / 100ps

module tb_keyword_token_scanner;
  import kts_pkg::*;

  typedef enum bit {ITEM_BYTE, ITEM_END} item_kind_e;
  typedef enum bit [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_STRING} scan_state_e;

  class token_scoreboard;
    token_t           awaited[$];
    int unsigned      failures;
    scan_state_e      state;
    bit [15:0]        line_no;
    bit [15:0]        col_no;
    bit [15:0]        tok_line;
    bit [15:0]        tok_col;
    bit [15:0]        tok_len;
    bit [2:0]         kw_live;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      state    = SCAN_IDLE;
      line_no  = 16'd1;
      col_no   = 16'd1;
      tok_line = 16'd1;
      tok_col  = 16'd1;
      tok_len  = 16'd0;
      kw_live  = 3'b111;
    endfunction

    function bit [15:0] bump(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit is_letter(bit [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function bit is_digit(bit [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void advance(bit [7:0] b);
      if (b == CH_LF) begin
        line_no = bump(line_no);
        col_no  = 16'd1;
      end else begin
        col_no = bump(col_no);
      end
    endfunction

    function void match_letter(bit [7:0] b);
      int idx;
      idx = int'(tok_len);
      if (idx >= MISSION_LEN || KW_MISSION[idx] != b) kw_live[0] = 1'b0;
      if (idx >= OBJECTIVE_LEN || KW_OBJECTIVE[idx] != b) kw_live[1] = 1'b0;
      if (idx >= XP_LEN || KW_XP[idx] != b) kw_live[2] = 1'b0;
    endfunction

    function void add(token_kind_t k, error_kind_t e, bit [7:0] bad,
                      bit [15:0] ln, bit [15:0] col, bit [15:0] len);
      token_t t;
      t.token_kind    = k;
      t.error_kind    = e;
      t.bad_character = bad;
      t.start_line    = ln;
      t.start_column  = col;
      t.token_length  = len;
      t.last_of_run   = 1'b0;
      awaited.push_back(t);
    endfunction

    function void close_pending();
      token_kind_t k;
      case (state)
        SCAN_WORD: begin
          k = TK_WORD;
          if (kw_live[0] && tok_len == MISSION_LEN) k = TK_MISSION;
          else if (kw_live[1] && tok_len == OBJECTIVE_LEN) k = TK_OBJECTIVE;
          else if (kw_live[2] && tok_len == XP_LEN) k = TK_XP;
          add(k, ERR_NONE, 8'h00, tok_line, tok_col, tok_len);
        end
        SCAN_NUMBER: add(TK_NUMBER, ERR_NONE, 8'h00, tok_line, tok_col, tok_len);
        SCAN_STRING: add(TK_ERROR, ERR_UNTERMINATED, 8'h00, tok_line, tok_col, tok_len);
        default: ;
      endcase
    endfunction

    function void scan_fresh(bit [7:0] b);
      tok_line = line_no;
      tok_col  = col_no;
      if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
      end else if (is_letter(b)) begin
        state   = SCAN_WORD;
        tok_len = 16'd0;
        kw_live = 3'b111;
        match_letter(b);
        tok_len = 16'd1;
      end else if (is_digit(b)) begin
        state   = SCAN_NUMBER;
        tok_len = 16'd1;
      end else if (b == CH_QUOTE) begin
        state   = SCAN_STRING;
        tok_len = 16'd0;
      end else if (b == CH_LBRACE) begin
        add(TK_LBRACE, ERR_NONE, 8'h00, line_no, col_no, 16'd1);
      end else if (b == CH_RBRACE) begin
        add(TK_RBRACE, ERR_NONE, 8'h00, line_no, col_no, 16'd1);
      end else if (b == CH_SEMI) begin
        add(TK_SEMICOLON, ERR_NONE, 8'h00, line_no, col_no, 16'd1);
      end else begin
        add(TK_ERROR, ERR_UNEXPECTED, b, line_no, col_no, 16'd1);
      end
      advance(b);
    endfunction

    // one accepted input transfer
    function void note_byte(item_kind_e kind, bit [7:0] b);
      int base;
      base = awaited.size();
      if (kind == ITEM_END) begin
        close_pending();
        add(TK_EOF, ERR_NONE, 8'h00, line_no, col_no, 16'd0);
        restart();
      end else if (state == SCAN_STRING) begin
        if (b == CH_QUOTE) begin
          add(TK_WORD, ERR_NONE, 8'h00, tok_line, tok_col, tok_len);
          state = SCAN_IDLE;
        end else begin
          tok_len = bump(tok_len);
        end
        advance(b);
      end else if ((state == SCAN_WORD && (is_letter(b) || is_digit(b))) ||
                   (state == SCAN_NUMBER && is_digit(b))) begin
        if (state == SCAN_WORD) match_letter(b);
        tok_len = bump(tok_len);
        advance(b);
      end else begin
        close_pending();
        state = SCAN_IDLE;
        scan_fresh(b);
      end
      if (awaited.size() > base) awaited[awaited.size() - 1].last_of_run = 1'b1;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        failures++;
      end
    endfunction

    function void check_token(token_t seen);
      token_t want;
      if (awaited.size() == 0) begin
        $error("token transfer with nothing outstanding: kind %0d line %0d col %0d",
               seen.token_kind, seen.start_line, seen.start_column);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare_field("token_kind", 16'(want.token_kind), 16'(seen.token_kind));
      compare_field("error_kind", 16'(want.error_kind), 16'(seen.error_kind));
      compare_field("bad_character", 16'(want.bad_character), 16'(seen.bad_character));
      compare_field("start_line", want.start_line, seen.start_line);
      compare_field("start_column", want.start_column, seen.start_column);
      compare_field("token_length", want.token_length, seen.token_length);
      compare_field("last_of_run", 16'(want.last_of_run), 16'(seen.last_of_run));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_kind = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       take_tokens = 1'b0;

  kts_byte_if  bytes_ch ();
  kts_token_if tokens_ch ();

  assign bytes_ch.valid      = in_valid;
  assign bytes_ch.kind       = in_kind;
  assign bytes_ch.byte_value = in_byte;
  assign tokens_ch.ready     = take_tokens;

  keyword_token_scanner uut (
    .clk          (clk),
    .rst          (rst),
    .source_bytes (bytes_ch),
    .tokens       (tokens_ch)
  );

  token_scoreboard sb = new();

  string       keywords[3] = '{"MISSION", "OBJECTIVE", "XP"};
  int          burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned sink_run = 0;
  bit [1:0]    sink_mode = 2'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of always-ready, random, stalled and alternating
  always @(posedge clk) begin
    if (sink_run == 0) begin
      sink_mode <= 2'($urandom_range(0, 3));
      sink_run  <= $urandom_range(1, 40);
    end else begin
      sink_run <= sink_run - 1;
    end
    case (sink_mode)
      2'd0: take_tokens <= 1'b1;
      2'd1: take_tokens <= 1'($urandom_range(0, 1));
      2'd2: take_tokens <= 1'b0;
      default: take_tokens <= ~take_tokens;
    endcase
  end

  always @(posedge clk) begin : token_monitor
    token_t seen;
    if (!rst && tokens_ch.valid && take_tokens) begin
      seen.token_kind    = token_kind_t'(tokens_ch.token_kind);
      seen.error_kind    = error_kind_t'(tokens_ch.error_kind);
      seen.bad_character = tokens_ch.bad_character;
      seen.start_line    = tokens_ch.start_line;
      seen.start_column  = tokens_ch.start_column;
      seen.token_length  = tokens_ch.token_length;
      seen.last_of_run   = tokens_ch.last_of_run;
      sb.check_token(seen);
    end
  end

  task automatic put_item(input item_kind_e kind, input bit [7:0] value);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_byte  <= value;
    do @(posedge clk); while (!(in_valid && bytes_ch.ready));
    sb.note_byte(kind, value);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(ITEM_BYTE, s[i]);
  endtask

  // hold off until every outstanding token has been taken
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic bit [7:0] rand_letter();
    return ($urandom_range(0, 1) == 0) ? 8'("A" + $urandom_range(0, 25))
                                       : 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic bit [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic bit [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic send_string_body(input int count);
    bit [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(32, 126));
      if (b == CH_QUOTE) b = CH_LF;
      put_item(ITEM_BYTE, b);
    end
  endtask

  task automatic random_fragment();
    int    roll;
    int    n;
    string s;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      send_text(keywords[$urandom_range(0, 2)]);
    end else if (roll < 20) begin
      s = keywords[$urandom_range(0, 2)];
      case ($urandom_range(0, 3))
        0: s = s.substr(0, s.len() - 2);
        1: s = {s, string'(($urandom_range(0, 1) == 0) ? rand_letter() : rand_digit())};
        2: s[$urandom_range(0, s.len() - 1)] = rand_letter();
        default: s = s.tolower();
      endcase
      send_text(s);
    end else if (roll < 35) begin
      put_item(ITEM_BYTE, rand_letter());
      n = $urandom_range(0, 11);
      for (int i = 0; i < n; i++)
        put_item(ITEM_BYTE, ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
    end else if (roll < 48) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) put_item(ITEM_BYTE, rand_digit());
    end else if (roll < 60) begin
      put_item(ITEM_BYTE, CH_QUOTE);
      send_string_body($urandom_range(0, 10));
      put_item(ITEM_BYTE, CH_QUOTE);
    end else if (roll < 73) begin
      case ($urandom_range(0, 2))
        0: put_item(ITEM_BYTE, CH_LBRACE);
        1: put_item(ITEM_BYTE, CH_RBRACE);
        default: put_item(ITEM_BYTE, CH_SEMI);
      endcase
    end else if (roll < 83) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) put_item(ITEM_BYTE, rand_blank());
    end else if (roll < 92) begin
      put_item(ITEM_BYTE, 8'($urandom_range(0, 255)));
    end else if (roll < 97) begin
      put_item(ITEM_END, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0) drain();
    end else begin
      put_item(ITEM_BYTE, CH_QUOTE);
      send_string_body($urandom_range(0, 6));
      put_item(ITEM_END, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1) == 0) put_item(ITEM_BYTE, rand_blank());
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // keyword ending on a brace, number then letter, string over a newline,
    // bad characters at both byte extremes, unterminated string at the end
    send_text("XP{9a\"x\n\"_;} ");
    put_item(ITEM_BYTE, 8'hFF);
    put_item(ITEM_BYTE, 8'h00);
    put_item(ITEM_BYTE, CH_TAB);
    put_item(ITEM_BYTE, CH_CR);
    put_item(ITEM_BYTE, CH_QUOTE);
    put_item(ITEM_BYTE, "q");
    put_item(ITEM_END, 8'hA5);
    drain();

    target = items_sent + 1050;
    while (items_sent < target) random_fragment();
    put_item(ITEM_END, 8'h00);

    drain();
    repeat (8) @(posedge clk);
    if (sb.failures == 0)
      $display("tb_keyword_token_scanner passed");
    else
      $display("tb_keyword_token_scanner failed");
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("tb_keyword_token_scanner failed");
    $finish;
  end

endmodule
